// ===== rtl/fbslp_pkg.sv =====
package fbslp_pkg;

  localparam int ACTION_W   = 2;
  localparam int SWITCH_W   = 4;
  localparam int INDEX_W    = 2;
  localparam int COUNT_W    = 8;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int FIELD_SWITCHES = 4;

  localparam logic [CFG_DATA_W-1:0] BEGIN_RESET    = 16'd100;
  localparam logic [CFG_DATA_W-1:0] INTERVAL_RESET = 16'd20;

  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK   = 2'd0,
    ACT_IGNORE = 2'd1,
    ACT_READ   = 2'd2,
    ACT_NOP    = 2'd3
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BEGIN    = 1'b0,
    CFG_INTERVAL = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic tick;
    logic down;
    logic set_ignore;
    logic read_clear;
  } cell_ctrl_t;

  typedef struct packed {
    logic short_seen;
    logic hit;
  } cell_stat_t;

endpackage

// ===== rtl/fbslp_in_if.sv =====
interface fbslp_in_if;
  import fbslp_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [SWITCH_W-1:0] switch_down;
  logic [INDEX_W-1:0]  switch_index;

  modport source (output valid, action, switch_down, switch_index, input ready);
  modport sink   (input valid, action, switch_down, switch_index, output ready);
endinterface

// ===== rtl/fbslp_out_if.sv =====
interface fbslp_out_if;
  import fbslp_pkg::*;

  logic                valid;
  logic                ready;
  logic                detected;
  logic [SWITCH_W-1:0] pressed_mask;
  logic [COUNT_W-1:0]  long_count_a;
  logic [COUNT_W-1:0]  long_count_b;
  logic [COUNT_W-1:0]  long_count_c;
  logic [COUNT_W-1:0]  long_count_d;

  modport source (output valid, detected, pressed_mask, long_count_a, long_count_b,
                  long_count_c, long_count_d, input ready);
  modport sink   (input valid, detected, pressed_mask, long_count_a, long_count_b,
                  long_count_c, long_count_d, output ready);
endinterface

// ===== rtl/fbslp_cfg_if.sv =====
interface fbslp_cfg_if;
  import fbslp_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/fbslp_cell.sv =====
module fbslp_cell #(
  parameter int HOLD_WIDTH       = 16,
  parameter int LONG_COUNT_WIDTH = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  fbslp_pkg::cell_ctrl_t             ctrl,
  input  logic [fbslp_pkg::CFG_DATA_W-1:0]  long_begin,
  input  logic [fbslp_pkg::CFG_DATA_W-1:0]  long_interval,
  output fbslp_pkg::cell_stat_t             stat,
  output logic [LONG_COUNT_WIDTH-1:0]       long_count
);
  import fbslp_pkg::*;

  localparam int CW = (HOLD_WIDTH > CFG_DATA_W) ? HOLD_WIDTH : CFG_DATA_W;

  logic [HOLD_WIDTH-1:0]       hold_r, hold_nxt;
  logic [HOLD_WIDTH-1:0]       phase_r, phase_nxt;
  logic                        pend_r, pend_nxt;
  logic                        ign_r, ign_nxt;
  logic                        seen_r, seen_nxt;
  logic [LONG_COUNT_WIDTH-1:0] cnt_r, cnt_nxt;

  logic [HOLD_WIDTH-1:0] hold_now;
  logic [CW-1:0]         old_ext, now_ext, begin_ext;
  logic [CW:0]           phase_inc, interval_ext;
  logic                  bump;
  logic                  hit;

  always_comb begin
    hold_now     = (&hold_r) ? hold_r : hold_r + 1'b1;
    old_ext      = CW'(hold_r);
    now_ext      = CW'(hold_now);
    begin_ext    = CW'(long_begin);
    phase_inc    = (CW + 1)'(phase_r) + 1'b1;
    interval_ext = (CW + 1)'(long_interval);

    hold_nxt  = hold_r;
    phase_nxt = phase_r;
    pend_nxt  = pend_r;
    ign_nxt   = ign_r;
    seen_nxt  = seen_r;
    cnt_nxt   = cnt_r;
    bump      = 1'b0;
    hit       = 1'b0;

    if (ctrl.tick) begin
      if (ctrl.down) begin
        if (hold_r == '0) begin
          pend_nxt = 1'b1;
        end
        hold_nxt = hold_now;
        if (now_ext >= begin_ext) begin
          if (old_ext < begin_ext) begin
            phase_nxt = '0;
            bump      = 1'b1;
          end else if (phase_inc >= interval_ext) begin
            phase_nxt = '0;
            bump      = 1'b1;
          end else begin
            phase_nxt = phase_inc[HOLD_WIDTH-1:0];
          end
          pend_nxt = 1'b0;
        end
        if (bump && !ign_r) begin
          if (!(&cnt_r)) begin
            cnt_nxt = cnt_r + 1'b1;
          end
          hit = 1'b1;
        end
      end else begin
        if (pend_r) begin
          seen_nxt = 1'b1;
          hit      = 1'b1;
        end
        pend_nxt  = 1'b0;
        hold_nxt  = '0;
        phase_nxt = '0;
        cnt_nxt   = '0;
        ign_nxt   = 1'b0;
      end
    end

    if (ctrl.set_ignore) begin
      ign_nxt = 1'b1;
    end

    if (ctrl.read_clear) begin
      seen_nxt = 1'b0;
      cnt_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r  <= '0;
      phase_r <= '0;
      pend_r  <= 1'b0;
      ign_r   <= 1'b0;
      seen_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      hold_r  <= hold_nxt;
      phase_r <= phase_nxt;
      pend_r  <= pend_nxt;
      ign_r   <= ign_nxt;
      seen_r  <= seen_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign stat.short_seen = seen_r;
  assign stat.hit        = hit;
  assign long_count      = cnt_r;

endmodule

// ===== rtl/four_button_short_long_press.sv =====
// A read item's result is offered from the result register, behind the input register.
// Throughput: one item per cycle unless a read stalls; the input register moves on
// for a read only when the result register is free or is emptied in the same cycle.
// Reset (synchronous, active low) clears all switch state, both handshakes and
// restores the hold threshold to 100 ticks and the repeat interval to 20 ticks.
module four_button_short_long_press #(
  parameter int NUM_SWITCHES     = 4,
  parameter int HOLD_WIDTH       = 16,
  parameter int LONG_COUNT_WIDTH = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  fbslp_in_if.sink    in_ch,
  fbslp_out_if.source out_ch,
  fbslp_cfg_if.sink   cfg_ch
);
  import fbslp_pkg::*;

  logic [CFG_DATA_W-1:0] begin_r;
  logic [CFG_DATA_W-1:0] interval_r;

  logic                s1_valid_r;
  action_t             s1_action_r;
  logic [SWITCH_W-1:0] s1_down_r;
  logic [INDEX_W-1:0]  s1_index_r;

  logic                out_valid_r;
  logic                out_detected_r;
  logic [SWITCH_W-1:0] out_mask_r;
  logic [FIELD_SWITCHES-1:0][COUNT_W-1:0] out_count_r;

  logic any_detected_r, any_detected_nxt;

  logic s1_is_read;
  logic advance;
  logic in_take;

  cell_ctrl_t [NUM_SWITCHES-1:0] cell_ctrl;
  cell_stat_t [NUM_SWITCHES-1:0] cell_stat;
  logic [NUM_SWITCHES-1:0][LONG_COUNT_WIDTH-1:0] cell_count;
  logic [NUM_SWITCHES-1:0] cell_hit;

  logic [SWITCH_W-1:0] mask_now;
  logic [FIELD_SWITCHES-1:0][COUNT_W-1:0] count_now;

  assign s1_is_read   = (s1_action_r == ACT_READ);
  assign advance      = s1_valid_r && (!s1_is_read || !out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || advance;
  assign in_take      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      begin_r    <= BEGIN_RESET;
      interval_r <= INTERVAL_RESET;
    end else if (cfg_ch.valid) begin
      case (cfg_index_t'(cfg_ch.index))
        CFG_BEGIN:    begin_r    <= cfg_ch.data;
        CFG_INTERVAL: interval_r <= cfg_ch.data;
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_action_r <= action_t'(in_ch.action);
      s1_down_r   <= in_ch.switch_down;
      s1_index_r  <= in_ch.switch_index;
    end
  end

  for (genvar s = 0; s < NUM_SWITCHES; s++) begin : g_cell
    if (s < FIELD_SWITCHES) begin : g_field
      assign cell_ctrl[s].down       = s1_down_r[s];
      assign cell_ctrl[s].set_ignore = advance && (s1_action_r == ACT_IGNORE)
                                       && (s1_index_r == INDEX_W'(s));
      assign mask_now[s]             = cell_stat[s].short_seen;
      if (LONG_COUNT_WIDTH >= COUNT_W) begin : g_trunc
        assign count_now[s] = cell_count[s][COUNT_W-1:0];
      end else begin : g_ext
        assign count_now[s] = COUNT_W'(cell_count[s]);
      end
    end else begin : g_extra
      assign cell_ctrl[s].down       = 1'b0;
      assign cell_ctrl[s].set_ignore = 1'b0;
    end
    assign cell_ctrl[s].tick       = advance && (s1_action_r == ACT_TICK);
    assign cell_ctrl[s].read_clear = advance && s1_is_read;
    assign cell_hit[s]             = cell_stat[s].hit;

    fbslp_cell #(
      .HOLD_WIDTH       (HOLD_WIDTH),
      .LONG_COUNT_WIDTH (LONG_COUNT_WIDTH)
    ) u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .ctrl          (cell_ctrl[s]),
      .long_begin    (begin_r),
      .long_interval (interval_r),
      .stat          (cell_stat[s]),
      .long_count    (cell_count[s])
    );
  end

  for (genvar s = NUM_SWITCHES; s < FIELD_SWITCHES; s++) begin : g_absent
    assign mask_now[s]  = 1'b0;
    assign count_now[s] = '0;
  end

  always_comb begin
    any_detected_nxt = any_detected_r;
    if (|cell_hit) begin
      any_detected_nxt = 1'b1;
    end
    if (advance && s1_is_read) begin
      any_detected_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      any_detected_r <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      any_detected_r <= any_detected_nxt;
      if (advance && s1_is_read) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_is_read) begin
      out_detected_r <= any_detected_r;
      out_mask_r     <= mask_now;
      out_count_r    <= count_now;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.detected     = out_detected_r;
  assign out_ch.pressed_mask = out_mask_r;
  assign out_ch.long_count_a = out_count_r[0];
  assign out_ch.long_count_b = out_count_r[1];
  assign out_ch.long_count_c = out_count_r[2];
  assign out_ch.long_count_d = out_count_r[3];

endmodule

// ===== tb/four_button_short_long_press_tb.sv =====
`timescale 1ns / 100ps

module four_button_short_long_press_tb;
  import fbslp_pkg::*;

  localparam int unsigned HOLD_LIMIT = 16'hFFFF;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    logic                               detected;
    logic [SWITCH_W-1:0]                pressed_mask;
    logic [FIELD_SWITCHES-1:0][COUNT_W-1:0] counts;
  } read_result_t;

  logic clk;
  logic rst_n;

  fbslp_in_if  in_ch ();
  fbslp_out_if out_ch ();
  fbslp_cfg_if cfg_ch ();

  four_button_short_long_press DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Expected switch state, kept in step with every accepted item.
  logic [CFG_DATA_W-1:0] hold_begin;
  logic [CFG_DATA_W-1:0] repeat_interval;
  logic [15:0]           sw_hold    [FIELD_SWITCHES];
  logic [15:0]           sw_phase   [FIELD_SWITCHES];
  logic                  sw_pending [FIELD_SWITCHES];
  logic                  sw_ignore  [FIELD_SWITCHES];
  logic                  sw_short   [FIELD_SWITCHES];
  logic [COUNT_W-1:0]    sw_count   [FIELD_SWITCHES];
  logic                  press_flag;

  read_result_t expected_reads[$];
  int unsigned  mismatches;

  int unsigned gap_max = 9;
  bit          tx_steady;
  bit          rx_steady;
  int unsigned rx_wait;
  int unsigned rx_hold;
  int unsigned rx_hold_request;

  function automatic void reset_press_state();
    hold_begin      = BEGIN_RESET;
    repeat_interval = INTERVAL_RESET;
    for (int s = 0; s < FIELD_SWITCHES; s++) begin
      sw_hold[s]    = '0;
      sw_phase[s]   = '0;
      sw_pending[s] = 1'b0;
      sw_ignore[s]  = 1'b0;
      sw_short[s]   = 1'b0;
      sw_count[s]   = '0;
    end
    press_flag = 1'b0;
  endfunction

  function automatic void bump_repeat(int s);
    if (!sw_ignore[s]) begin
      if (sw_count[s] != '1) begin
        sw_count[s] = sw_count[s] + 1'b1;
      end
      press_flag = 1'b1;
    end
  endfunction

  function automatic void apply_press_item(action_t act, logic [SWITCH_W-1:0] down,
                                           logic [INDEX_W-1:0] idx);
    read_result_t r;
    int unsigned  old_h;
    int unsigned  new_h;
    int unsigned  ph;
    int unsigned  begin_w;
    int unsigned  interval_w;
    begin_w    = 32'(hold_begin);
    interval_w = 32'(repeat_interval);
    case (act)
      ACT_TICK: begin
        for (int s = 0; s < FIELD_SWITCHES; s++) begin
          if (down[s]) begin
            old_h = 32'(sw_hold[s]);
            if (old_h == 0) begin
              sw_pending[s] = 1'b1;
            end
            new_h = (old_h < HOLD_LIMIT) ? old_h + 1 : old_h;
            sw_hold[s] = new_h[15:0];
            if (new_h >= begin_w) begin
              if (old_h < begin_w) begin
                sw_phase[s] = '0;
                bump_repeat(s);
              end else begin
                ph = 32'(sw_phase[s]) + 1;
                if (ph >= interval_w) begin
                  ph = 0;
                  bump_repeat(s);
                end
                sw_phase[s] = ph[15:0];
              end
              sw_pending[s] = 1'b0;
            end
          end else begin
            if (sw_pending[s]) begin
              sw_short[s] = 1'b1;
              press_flag  = 1'b1;
            end
            sw_pending[s] = 1'b0;
            sw_hold[s]    = '0;
            sw_phase[s]   = '0;
            sw_count[s]   = '0;
            sw_ignore[s]  = 1'b0;
          end
        end
      end
      ACT_IGNORE: begin
        sw_ignore[idx] = 1'b1;
      end
      ACT_READ: begin
        r.detected = press_flag;
        for (int s = 0; s < FIELD_SWITCHES; s++) begin
          r.pressed_mask[s] = sw_short[s];
          r.counts[s]       = sw_count[s];
          sw_short[s]       = 1'b0;
          sw_count[s]       = '0;
        end
        press_flag = 1'b0;
        expected_reads.push_back(r);
      end
      default: begin
      end
    endcase
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      end
    end
  endtask

  task automatic check_read_result();
    read_result_t want;
    if (expected_reads.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
        $display("%0t: read result with none outstanding", $time);
      end
    end else begin
      want = expected_reads.pop_front();
      check_field("detected", 32'(want.detected), 32'(out_ch.detected));
      check_field("pressed_mask", 32'(want.pressed_mask), 32'(out_ch.pressed_mask));
      check_field("long_count_a", 32'(want.counts[0]), 32'(out_ch.long_count_a));
      check_field("long_count_b", 32'(want.counts[1]), 32'(out_ch.long_count_b));
      check_field("long_count_c", 32'(want.counts[2]), 32'(out_ch.long_count_c));
      check_field("long_count_d", 32'(want.counts[3]), 32'(out_ch.long_count_d));
    end
  endtask

  // Receiver: random stalls after each result, plus a long hold-off on request.
  always @(posedge clk) begin
    if (rx_hold_request != 0) begin
      rx_hold         = rx_hold_request;
      rx_hold_request = 0;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      check_read_result();
      rx_wait = rx_steady ? 0 : $urandom_range(9);
      if ($urandom_range(19) == 0) begin
        rx_steady = !rx_steady;
      end
    end
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold--;
      out_ch.ready <= 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  task automatic send_item(action_t act, logic [SWITCH_W-1:0] down, logic [INDEX_W-1:0] idx);
    int unsigned gap;
    gap = tx_steady ? 0 : $urandom_range(gap_max);
    if ($urandom_range(39) == 0) begin
      tx_steady = !tx_steady;
    end
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.action       <= act;
    in_ch.switch_down  <= down;
    in_ch.switch_index <= idx;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    apply_press_item(act, down, idx);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (expected_reads.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_timing(logic [CFG_DATA_W-1:0] begin_ticks,
                            logic [CFG_DATA_W-1:0] interval_ticks);
    settle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= CFG_BEGIN;
    cfg_ch.data  <= begin_ticks;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    hold_begin = begin_ticks;
    cfg_ch.index <= CFG_INTERVAL;
    cfg_ch.data  <= interval_ticks;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    repeat_interval = interval_ticks;
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic test_idle_reads();
    send_item(ACT_READ, 4'h0, 2'd0);
    send_item(ACT_NOP, 4'hF, 2'd3);
    for (int i = 0; i < FIELD_SWITCHES; i++) begin
      send_item(ACT_IGNORE, 4'h0, i[INDEX_W-1:0]);
    end
    send_item(ACT_TICK, 4'h0, 2'd3);
    send_item(ACT_READ, 4'hF, 2'd3);
  endtask

  task automatic test_short_presses();
    send_item(ACT_TICK, 4'hF, 2'd0);
    send_item(ACT_TICK, 4'h0, 2'd0);
    send_item(ACT_READ, 4'h0, 2'd0);
    send_item(ACT_TICK, 4'h5, 2'd0);
    send_item(ACT_TICK, 4'h0, 2'd0);
    send_item(ACT_TICK, 4'hA, 2'd0);
    send_item(ACT_TICK, 4'h0, 2'd0);
    send_item(ACT_READ, 4'h0, 2'd0);
  endtask

  task automatic test_long_repeat();
    set_timing(16'd3, 16'd2);
    repeat (6) send_item(ACT_TICK, 4'h9, 2'd0);
    send_item(ACT_READ, 4'h0, 2'd0);
    send_item(ACT_IGNORE, 4'h0, 2'd0);
    repeat (4) send_item(ACT_TICK, 4'h9, 2'd1);
    send_item(ACT_READ, 4'h0, 2'd0);
    send_item(ACT_TICK, 4'h8, 2'd0);
    send_item(ACT_TICK, 4'h0, 2'd0);
    send_item(ACT_READ, 4'h0, 2'd0);
  endtask

  task automatic test_zero_timing();
    set_timing(16'd0, 16'd0);
    repeat (3) send_item(ACT_TICK, 4'hF, 2'd0);
    send_item(ACT_READ, 4'h0, 2'd0);
    send_item(ACT_TICK, 4'h0, 2'd0);
    send_item(ACT_READ, 4'h0, 2'd0);
  endtask

  task automatic test_count_saturation();
    set_timing(16'd1, 16'd1);
    repeat (260) send_item(ACT_TICK, 4'h9, 2'd0);
    send_item(ACT_READ, 4'h0, 2'd0);
    repeat (4) send_item(ACT_TICK, 4'h9, 2'd0);
    send_item(ACT_TICK, 4'h0, 2'd0);
    send_item(ACT_READ, 4'h0, 2'd0);
  endtask

  task automatic test_output_backpressure();
    set_timing(16'd2, 16'd1);
    gap_max         = 0;
    rx_hold_request = 150;
    for (int i = 0; i < 12; i++) begin
      send_item(ACT_TICK, 4'h3, 2'd0);
      send_item(ACT_READ, 4'h0, 2'd0);
    end
    send_item(ACT_TICK, 4'h0, 2'd0);
    send_item(ACT_READ, 4'h0, 2'd0);
    gap_max = 9;
  endtask

  // Switch levels change now and then, so presses of varied lengths occur.
  task automatic test_random_phase(logic [CFG_DATA_W-1:0] begin_ticks,
                                   logic [CFG_DATA_W-1:0] interval_ticks, int unsigned n);
    logic [SWITCH_W-1:0] level;
    logic [SWITCH_W-1:0] flips;
    int unsigned         pick;
    set_timing(begin_ticks, interval_ticks);
    level = '0;
    for (int unsigned k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        for (int s = 0; s < FIELD_SWITCHES; s++) begin
          flips[s] = ($urandom_range(5) == 0);
        end
        level = level ^ flips;
        send_item(ACT_TICK, level, INDEX_W'($urandom_range(3)));
      end else if (pick < 76) begin
        send_item(ACT_TICK, SWITCH_W'($urandom_range(15)), INDEX_W'($urandom_range(3)));
      end else if (pick < 82) begin
        send_item(ACT_IGNORE, SWITCH_W'($urandom_range(15)), INDEX_W'($urandom_range(3)));
      end else if (pick < 85) begin
        send_item(ACT_NOP, SWITCH_W'($urandom_range(15)), INDEX_W'($urandom_range(3)));
      end else begin
        send_item(ACT_READ, SWITCH_W'($urandom_range(15)), INDEX_W'($urandom_range(3)));
      end
    end
  endtask

  initial begin
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.action       <= ACT_NOP;
    in_ch.switch_down  <= '0;
    in_ch.switch_index <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.index       <= CFG_BEGIN;
    cfg_ch.data        <= '0;
    reset_press_state();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_idle_reads();
    test_short_presses();
    test_long_repeat();
    test_zero_timing();
    test_count_saturation();
    test_output_backpressure();
    test_random_phase(16'd2, 16'd1, 236);
    test_random_phase(16'd0, 16'd0, 236);
    test_random_phase(16'd4, 16'd3, 236);
    test_random_phase(16'd1, 16'hFFFF, 236);
    test_random_phase(16'hFFFF, 16'd1, 236);
    test_random_phase(16'd7, 16'd2, 236);
    settle();

    if (mismatches == 0 && expected_reads.size() == 0) begin
      $display("four_button_short_long_press_tb: clean");
    end else begin
      $display("four_button_short_long_press_tb: errors");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("four_button_short_long_press_tb: errors");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/fbslp_pkg.sv
rtl/fbslp_in_if.sv
rtl/fbslp_out_if.sv
rtl/fbslp_cfg_if.sv
rtl/fbslp_cell.sv
rtl/four_button_short_long_press.sv
tb/four_button_short_long_press_tb.sv
